// ----- src/tnaa_pkg.sv -----
// Shared constants for the triangle normal and area pipeline.
package tnaa_pkg;

  // Default coordinate width of one corner component.
  localparam int COORD_BITS_DEF = 16;

  // Fraction bits of the Q1.14 normal components.
  localparam int FRAC_BITS = 14;

  // Quotient bits needed for a magnitude of up to 2^FRAC_BITS.
  localparam int QUOT_BITS = FRAC_BITS + 1;

  // Width of one normal component on the result channel.
  localparam int NORM_BITS = 16;

  // Width of the minimum length register and of the area result.
  localparam int LEN_BITS  = 16;
  localparam int AREA_BITS = 33;

  // Reset value of the minimum length and the saturation value of the area.
  localparam logic [LEN_BITS-1:0]  MIN_LEN_RESET = 16'd1;
  localparam logic [AREA_BITS-1:0] AREA_MAX      = 33'h1_FFFF_FFFF;

endpackage

// ----- src/tnaa_front.sv -----
// Front pipeline: edge vectors, cross product and the sum of squares.
module tnaa_front #(
  parameter int COORD_BITS = tnaa_pkg::COORD_BITS_DEF
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 en,
  input  logic                                 in_valid,
  input  logic [COORD_BITS-1:0]                ax,
  input  logic [COORD_BITS-1:0]                ay,
  input  logic [COORD_BITS-1:0]                az,
  input  logic [COORD_BITS-1:0]                bx,
  input  logic [COORD_BITS-1:0]                by_coord,
  input  logic [COORD_BITS-1:0]                bz,
  input  logic [COORD_BITS-1:0]                cx,
  input  logic [COORD_BITS-1:0]                cy,
  input  logic [COORD_BITS-1:0]                cz,
  output logic                                 out_valid,
  output logic [2:0][2*COORD_BITS+1:0]         out_mag,
  output logic [2:0]                           out_neg,
  output logic [4*COORD_BITS+3:0]              out_sum
);

  localparam int EW = COORD_BITS + 1;   // edge component
  localparam int PW = 2 * EW;           // product and cross component
  localparam int MB = PW;               // cross magnitude
  localparam int H  = MB / 2;           // half of a magnitude
  localparam int SB = 2 * MB;           // square and sum of squares

  // Signed product at full width.
  function automatic logic [PW-1:0] smul(input logic signed [EW-1:0] a,
                                         input logic signed [EW-1:0] b);
    logic signed [PW-1:0] aw;
    logic signed [PW-1:0] bw;
    aw = PW'(a);
    bw = PW'(b);
    return aw * bw;
  endfunction

  logic [5:0] vld_r;

  logic signed [EW-1:0] e1x_r, e1y_r, e1z_r, e2x_r, e2y_r, e2z_r;
  logic [2:0][PW-1:0]   pa_r, pb_r;
  logic [2:0][MB-1:0]   mag3_r, mag4_r, mag5_r, mag6_r;
  logic [2:0]           neg3_r, neg4_r, neg5_r, neg6_r;
  logic [2:0][2*H-1:0]  hh_r, hl_r, ll_r;
  logic [2:0][SB-1:0]   sq_r;
  logic [SB-1:0]        sum_r;

  logic [2:0][MB-1:0]   mag_nxt;
  logic [2:0]           neg_nxt;
  logic [2:0][SB-1:0]   sq_nxt;
  logic [PW-1:0]        diff;

  // Valid bits travel with the items.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= {vld_r[4:0], in_valid};
    end
  end

  // Sign and magnitude of each cross component.
  always_comb begin
    diff = '0;
    for (int i = 0; i < 3; i++) begin
      diff       = PW'($signed(pa_r[i]) - $signed(pb_r[i]));
      neg_nxt[i] = diff[PW-1];
      mag_nxt[i] = diff[PW-1] ? MB'(-diff) : diff;
    end
  end

  // Square of each magnitude from its three partial products.
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      sq_nxt[i] = (SB'(hh_r[i]) << (2 * H)) + (SB'(hl_r[i]) << (H + 1)) + SB'(ll_r[i]);
    end
  end

  // Payload stages.
  always_ff @(posedge clk) begin
    if (en) begin
      e1x_r <= {bx[COORD_BITS-1], bx} - {ax[COORD_BITS-1], ax};
      e1y_r <= {by_coord[COORD_BITS-1], by_coord} - {ay[COORD_BITS-1], ay};
      e1z_r <= {bz[COORD_BITS-1], bz} - {az[COORD_BITS-1], az};
      e2x_r <= {cx[COORD_BITS-1], cx} - {ax[COORD_BITS-1], ax};
      e2y_r <= {cy[COORD_BITS-1], cy} - {ay[COORD_BITS-1], ay};
      e2z_r <= {cz[COORD_BITS-1], cz} - {az[COORD_BITS-1], az};

      pa_r[0] <= smul(e1y_r, e2z_r);
      pb_r[0] <= smul(e1z_r, e2y_r);
      pa_r[1] <= smul(e1z_r, e2x_r);
      pb_r[1] <= smul(e1x_r, e2z_r);
      pa_r[2] <= smul(e1x_r, e2y_r);
      pb_r[2] <= smul(e1y_r, e2x_r);

      mag3_r <= mag_nxt;
      neg3_r <= neg_nxt;

      for (int i = 0; i < 3; i++) begin
        hh_r[i] <= mag3_r[i][MB-1:H] * mag3_r[i][MB-1:H];
        hl_r[i] <= mag3_r[i][MB-1:H] * mag3_r[i][H-1:0];
        ll_r[i] <= mag3_r[i][H-1:0] * mag3_r[i][H-1:0];
      end
      mag4_r <= mag3_r;
      neg4_r <= neg3_r;

      sq_r   <= sq_nxt;
      mag5_r <= mag4_r;
      neg5_r <= neg4_r;

      sum_r  <= sq_r[0] + sq_r[1] + sq_r[2];
      mag6_r <= mag5_r;
      neg6_r <= neg5_r;
    end
  end

  assign out_valid = vld_r[5];
  assign out_mag   = mag6_r;
  assign out_neg   = neg6_r;
  assign out_sum   = sum_r;

endmodule

// ----- src/tnaa_sqrt.sv -----
// Square root pipeline: one root bit per stage.
module tnaa_sqrt #(
  parameter int COORD_BITS = tnaa_pkg::COORD_BITS_DEF
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         en,
  input  logic                         in_valid,
  input  logic [4*COORD_BITS+3:0]      in_sum,
  input  logic [2:0][2*COORD_BITS+1:0] in_mag,
  input  logic [2:0]                   in_neg,
  output logic                         out_valid,
  output logic [2*COORD_BITS+1:0]      out_root,
  output logic [2:0][2*COORD_BITS+1:0] out_mag,
  output logic [2:0]                   out_neg
);

  localparam int MB = 2 * COORD_BITS + 2;
  localparam int DB = MB;
  localparam int SB = 2 * MB;

  logic                vld_q [0:DB];
  logic [SB-1:0]       num_q [0:DB];
  logic [SB-1:0]       res_q [0:DB];
  logic [2:0][MB-1:0]  mag_q [0:DB];
  logic [2:0]          neg_q [0:DB];

  assign vld_q[0] = in_valid;
  assign num_q[0] = in_sum;
  assign res_q[0] = '0;
  assign mag_q[0] = in_mag;
  assign neg_q[0] = in_neg;

  for (genvar g = 0; g < DB; g++) begin : g_stage
    localparam int K = DB - 1 - g;

    logic [SB-1:0] bitv;
    logic [SB-1:0] trial;
    logic [SB-1:0] num_nxt;
    logic [SB-1:0] res_nxt;

    // Try the next root bit against the remaining radicand.
    always_comb begin
      bitv  = SB'(1) << (2 * K);
      trial = res_q[g] + bitv;
      if (num_q[g] >= trial) begin
        num_nxt = num_q[g] - trial;
        res_nxt = (res_q[g] >> 1) + bitv;
      end else begin
        num_nxt = num_q[g];
        res_nxt = res_q[g] >> 1;
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_q[g+1] <= 1'b0;
      end else if (en) begin
        vld_q[g+1] <= vld_q[g];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        num_q[g+1] <= num_nxt;
        res_q[g+1] <= res_nxt;
        mag_q[g+1] <= mag_q[g];
        neg_q[g+1] <= neg_q[g];
      end
    end
  end

  assign out_valid = vld_q[DB];
  assign out_root  = res_q[DB][DB-1:0];
  assign out_mag   = mag_q[DB];
  assign out_neg   = neg_q[DB];

endmodule

// ----- src/tnaa_div.sv -----
// Back pipeline: length clamp, area, and three rounded divisions to Q1.14.
module tnaa_div #(
  parameter int COORD_BITS = tnaa_pkg::COORD_BITS_DEF
) (
  input  logic                                      clk,
  input  logic                                      rst_n,
  input  logic                                      en,
  input  logic [tnaa_pkg::LEN_BITS-1:0]             min_length,
  input  logic                                      in_valid,
  input  logic [2*COORD_BITS+1:0]                   in_root,
  input  logic [2:0][2*COORD_BITS+1:0]              in_mag,
  input  logic [2:0]                                in_neg,
  output logic                                      out_valid,
  output logic [2:0][tnaa_pkg::NORM_BITS-1:0]       out_norm,
  output logic [tnaa_pkg::AREA_BITS-1:0]            out_area
);

  localparam int DB = 2 * COORD_BITS + 2;
  localparam int QB = tnaa_pkg::QUOT_BITS;
  localparam int AB = tnaa_pkg::AREA_BITS;
  localparam int NB = tnaa_pkg::NORM_BITS;
  localparam int HW = (DB - 1 > AB) ? DB - 1 : AB;

  // Pipeline taps: index 0 is the clamp stage, QB the last quotient stage.
  logic                 vld_q  [0:QB];
  logic [DB-1:0]        d_q    [0:QB];
  logic [2:0][DB-1:0]   rem_q  [0:QB];
  logic [2:0][QB-1:0]   quo_q  [0:QB];
  logic [2:0]           neg_q  [0:QB];
  logic [AB-1:0]        area_q [0:QB];
  logic [2:0]           lsb_r;

  // Clamp the length up to the configured minimum, zero acting as one.
  logic [DB-1:0] lim;
  logic [DB-1:0] d_nxt;
  logic [HW-1:0] half_w;
  logic [AB-1:0] area_nxt;

  always_comb begin
    lim      = (min_length == '0) ? DB'(1) : DB'(min_length);
    d_nxt    = (in_root < lim) ? lim : in_root;
    half_w   = HW'(d_nxt >> 1);
    area_nxt = (half_w > HW'(tnaa_pkg::AREA_MAX)) ? tnaa_pkg::AREA_MAX : half_w[AB-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_q[0] <= 1'b0;
    end else if (en) begin
      vld_q[0] <= in_valid;
    end
  end

  // The scaled numerator is the magnitude followed by FRAC_BITS zeros, so the
  // starting remainder is the magnitude without its low bit.
  always_ff @(posedge clk) begin
    if (en) begin
      d_q[0]    <= d_nxt;
      area_q[0] <= area_nxt;
      neg_q[0]  <= in_neg;
      quo_q[0]  <= '0;
      for (int i = 0; i < 3; i++) begin
        rem_q[0][i] <= DB'(in_mag[i] >> 1);
        lsb_r[i]    <= in_mag[i][0];
      end
    end
  end

  for (genvar g = 0; g < QB; g++) begin : g_stage
    logic [2:0][DB-1:0] rem_nxt;
    logic [2:0][QB-1:0] quo_nxt;
    logic [DB:0]        shifted;

    // One quotient bit per lane; only the first step shifts in a numerator bit.
    always_comb begin
      shifted = '0;
      for (int i = 0; i < 3; i++) begin
        shifted = {rem_q[g][i], (g == 0) ? lsb_r[i] : 1'b0};
        if (shifted >= {1'b0, d_q[g]}) begin
          rem_nxt[i] = DB'(shifted - {1'b0, d_q[g]});
          quo_nxt[i] = {quo_q[g][i][QB-2:0], 1'b1};
        end else begin
          rem_nxt[i] = shifted[DB-1:0];
          quo_nxt[i] = {quo_q[g][i][QB-2:0], 1'b0};
        end
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_q[g+1] <= 1'b0;
      end else if (en) begin
        vld_q[g+1] <= vld_q[g];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rem_q[g+1]  <= rem_nxt;
        quo_q[g+1]  <= quo_nxt;
        d_q[g+1]    <= d_q[g];
        neg_q[g+1]  <= neg_q[g];
        area_q[g+1] <= area_q[g];
      end
    end
  end

  // Round half away from zero and apply the sign.
  logic                 fin_vld_r;
  logic [2:0][NB-1:0]   norm_r;
  logic [2:0][NB-1:0]   norm_nxt;
  logic [AB-1:0]        area_r;
  logic [QB-1:0]        qr;

  always_comb begin
    qr = '0;
    for (int i = 0; i < 3; i++) begin
      qr = quo_q[QB][i];
      if ({rem_q[QB][i], 1'b0} >= {1'b0, d_q[QB]}) begin
        qr = qr + QB'(1);
      end
      norm_nxt[i] = neg_q[QB][i] ? NB'(-{1'b0, qr}) : NB'({1'b0, qr});
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fin_vld_r <= 1'b0;
    end else if (en) begin
      fin_vld_r <= vld_q[QB];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      norm_r <= norm_nxt;
      area_r <= area_q[QB];
    end
  end

  assign out_valid = fin_vld_r;
  assign out_norm  = norm_r;
  assign out_area  = area_r;

endmodule

// ----- src/triangle_normal_and_area.sv -----
// Top level: triangle unit normal and area, pipelined with an output skid.
//
//   channel  direction  handshake              payload
//   in_      input      in_valid / in_stall    nine corner coordinates
//   out_     output     out_valid / out_stall  normal_x/y/z (Q1.14), area
//   cfg_     input      cfg_we                 min_length (16 bit)
//
// One item enters per cycle while in_stall is low; the pipeline depth comes
// mostly from the square root pipeline, one root bit per stage, and the 15
// quotient stages of the divider lanes.
// Reset clears the valid bits and sets min_length to 1.
// When out_stall holds a result, the next one lands in a skid register; the
// whole pipeline halts only while that skid register is full.
module triangle_normal_and_area #(
  parameter int COORD_BITS = tnaa_pkg::COORD_BITS_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                cfg_we,
  input  logic [tnaa_pkg::LEN_BITS-1:0]       cfg_wdata,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic [COORD_BITS-1:0]               in_ax,
  input  logic [COORD_BITS-1:0]               in_ay,
  input  logic [COORD_BITS-1:0]               in_az,
  input  logic [COORD_BITS-1:0]               in_bx,
  input  logic [COORD_BITS-1:0]               in_by_coord,
  input  logic [COORD_BITS-1:0]               in_bz,
  input  logic [COORD_BITS-1:0]               in_cx,
  input  logic [COORD_BITS-1:0]               in_cy,
  input  logic [COORD_BITS-1:0]               in_cz,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic [tnaa_pkg::NORM_BITS-1:0]      out_normal_x,
  output logic [tnaa_pkg::NORM_BITS-1:0]      out_normal_y,
  output logic [tnaa_pkg::NORM_BITS-1:0]      out_normal_z,
  output logic [tnaa_pkg::AREA_BITS-1:0]      out_area
);

  localparam int MB = 2 * COORD_BITS + 2;
  localparam int SB = 2 * MB;
  localparam int NB = tnaa_pkg::NORM_BITS;
  localparam int AB = tnaa_pkg::AREA_BITS;

  // Minimum length register.
  logic [tnaa_pkg::LEN_BITS-1:0] min_len_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      min_len_r <= tnaa_pkg::MIN_LEN_RESET;
    end else if (cfg_we) begin
      min_len_r <= cfg_wdata;
    end
  end

  // The pipeline advances unless the skid register is occupied.
  logic skid_vld_r;
  logic en;

  assign en       = !skid_vld_r;
  assign in_stall = skid_vld_r;

  logic                f_vld;
  logic [2:0][MB-1:0]  f_mag;
  logic [2:0]          f_neg;
  logic [SB-1:0]       f_sum;

  tnaa_front #(.COORD_BITS(COORD_BITS)) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .in_valid  (in_valid),
    .ax        (in_ax),
    .ay        (in_ay),
    .az        (in_az),
    .bx        (in_bx),
    .by_coord  (in_by_coord),
    .bz        (in_bz),
    .cx        (in_cx),
    .cy        (in_cy),
    .cz        (in_cz),
    .out_valid (f_vld),
    .out_mag   (f_mag),
    .out_neg   (f_neg),
    .out_sum   (f_sum)
  );

  logic                s_vld;
  logic [MB-1:0]       s_root;
  logic [2:0][MB-1:0]  s_mag;
  logic [2:0]          s_neg;

  tnaa_sqrt #(.COORD_BITS(COORD_BITS)) u_sqrt (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .in_valid  (f_vld),
    .in_sum    (f_sum),
    .in_mag    (f_mag),
    .in_neg    (f_neg),
    .out_valid (s_vld),
    .out_root  (s_root),
    .out_mag   (s_mag),
    .out_neg   (s_neg)
  );

  logic                p_vld;
  logic [2:0][NB-1:0]  p_norm;
  logic [AB-1:0]       p_area;

  tnaa_div #(.COORD_BITS(COORD_BITS)) u_div (
    .clk        (clk),
    .rst_n      (rst_n),
    .en         (en),
    .min_length (min_len_r),
    .in_valid   (s_vld),
    .in_root    (s_root),
    .in_mag     (s_mag),
    .in_neg     (s_neg),
    .out_valid  (p_vld),
    .out_norm   (p_norm),
    .out_area   (p_area)
  );

  // Output register with a skid register behind it.
  logic                out_vld_r;
  logic [2:0][NB-1:0]  out_norm_r;
  logic [AB-1:0]       out_area_r;
  logic [2:0][NB-1:0]  skid_norm_r;
  logic [AB-1:0]       skid_area_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r  <= 1'b0;
      skid_vld_r <= 1'b0;
    end else if (out_vld_r && out_stall) begin
      if (en && p_vld) begin
        skid_vld_r <= 1'b1;
      end
    end else if (skid_vld_r) begin
      out_vld_r  <= 1'b1;
      skid_vld_r <= 1'b0;
    end else begin
      out_vld_r <= p_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (out_vld_r && out_stall) begin
      if (en && p_vld) begin
        skid_norm_r <= p_norm;
        skid_area_r <= p_area;
      end
    end else if (skid_vld_r) begin
      out_norm_r <= skid_norm_r;
      out_area_r <= skid_area_r;
    end else begin
      out_norm_r <= p_norm;
      out_area_r <= p_area;
    end
  end

  assign out_valid    = out_vld_r;
  assign out_normal_x = out_norm_r[0];
  assign out_normal_y = out_norm_r[1];
  assign out_normal_z = out_norm_r[2];
  assign out_area     = out_area_r;

endmodule
